// File: rtl/core/nta_pkg.sv
`default_nettype none

package nta_pkg;

    localparam int NTA_MAX_TRACKS = 8;

    localparam int POS_W     = 16;
    localparam int ID_W      = 16;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int DIST_W    = 15;
    localparam int FTD_W     = 10;
    localparam int LIM2_W    = 2 * DIST_W;
    localparam int MISSED_W  = 11;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int SQ_MAG_W  = 2 * POS_W + 1;
    localparam int D2_W      = SQ_MAG_W + 2;
    localparam int CFG_IDX_W = 1;

    localparam int RESET_MAX_DIST      = 819;
    localparam int RESET_FRAMES_TO_DIE = 30;

    localparam logic [MISSED_W-1:0] MISSED_SAT = {MISSED_W{1'b1}};

    typedef enum logic {
        CMD_FRAME  = 1'b0,
        CMD_DETECT = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_MATCH_DIST = 1'b0,
        REG_FRAMES_TO_DIE  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]    track_id;
        logic [SLOT_W-1:0]  slot;
        logic               is_new;
        logic               dropped;
        logic [COUNT_W-1:0] live_count;
        logic [COUNT_W-1:0] removed_count;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic frame_step;
        logic issue;
        logic commit;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/nta_ctrl.sv
`default_nettype none

module nta_ctrl import nta_pkg::*; #(
    parameter int MAX_TRACKS = NTA_MAX_TRACKS,
    parameter int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_cmd             i_cmd,
    input  wire t_dp_stat         i_stat,
    output logic                  o_busy,
    output logic                  o_res_valid,
    output t_dp_ctl               o_ctl,
    output logic [IDX_W-1:0]      o_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAME,
        S_DSCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx   <= '0;
                        r_state <= (i_cmd == CMD_DETECT) ? S_DSCAN : S_FRAME;
                    end
                end
                S_FRAME: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_DSCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the last slot to leave the distance pipe
                    if (!i_stat.pipe_busy) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_res_valid      = r_done;
    assign o_idx            = r_idx;
    assign o_ctl.load       = i_start && (r_state == S_IDLE);
    assign o_ctl.frame_step = (r_state == S_FRAME);
    assign o_ctl.issue      = (r_state == S_DSCAN);
    assign o_ctl.commit     = (r_state == S_COMMIT);

endmodule

`default_nettype wire

// File: rtl/core/nta_dp.sv
`default_nettype none

module nta_dp import nta_pkg::*; #(
    parameter int MAX_TRACKS = NTA_MAX_TRACKS,
    parameter int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
    parameter int CNT_W      = $clog2(MAX_TRACKS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_ctl           i_ctl,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_in               i_in,
    input  wire logic              i_cfg_we,
    input  wire t_reg_idx          i_cfg_index,
    input  wire logic [DIST_W-1:0] i_cfg_data,
    output t_dp_stat               o_stat,
    output t_out                   o_res
);

    localparam int POS3_W = 3 * POS_W;

    // configuration
    logic [LIM2_W-1:0] r_lim2;
    logic [FTD_W-1:0]  r_ftd;
    logic [LIM2_W-1:0] n_lim2;

    // current item
    t_cmd              r_cmd;
    logic [POS_W-1:0]  r_px, r_py, r_pz;

    // track table
    logic [MAX_TRACKS-1:0] r_valid;
    logic [MAX_TRACKS-1:0] r_found;
    logic [MISSED_W-1:0]   r_missed [MAX_TRACKS];
    logic [POS3_W-1:0]     mem_pos  [MAX_TRACKS];
    logic [ID_W-1:0]       mem_id   [MAX_TRACKS];
    logic [CNT_W-1:0]      r_live;
    logic [CNT_W-1:0]      r_removed;
    logic [ID_W-1:0]       r_next_id;

    // distance pipe
    logic [POS3_W-1:0]       r_rd_pos;
    logic [ID_W-1:0]         r_rd_id;
    logic                    r_s1_vld, r_s2_vld, r_s3_vld;
    logic [IDX_W-1:0]        r_s1_idx, r_s2_idx, r_s3_idx;
    logic [ID_W-1:0]         r_s2_id, r_s3_id;
    logic signed [DIFF_W-1:0] r_s2_dx, r_s2_dy, r_s2_dz;
    logic signed [SQ_W-1:0]  r_s3_sqx, r_s3_sqy, r_s3_sqz;

    // scan results
    logic              r_have_best, r_have_free;
    logic [IDX_W-1:0]  r_best_idx, r_free_idx;
    logic [D2_W-1:0]   r_best_d;
    logic [ID_W-1:0]   r_best_id;

    t_out              r_res;
    t_out              n_res;

    logic [D2_W-1:0]     d2;
    logic                elig, upd_best, upd_free;
    logic [MISSED_W-1:0] missed_inc;
    logic                kill;
    logic                det_commit;
    logic                mem_we, id_we;
    logic [IDX_W-1:0]    wr_idx;

    assign n_lim2 = i_cfg_data * i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim2 <= LIM2_W'(RESET_MAX_DIST * RESET_MAX_DIST);
            r_ftd  <= FTD_W'(RESET_FRAMES_TO_DIE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_MATCH_DIST: r_lim2 <= n_lim2;
                REG_FRAMES_TO_DIE:  r_ftd  <= i_cfg_data[FTD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in.cmd;
            r_px  <= i_in.pos_x;
            r_py  <= i_in.pos_y;
            r_pz  <= i_in.pos_z;
        end
    end

    // frame step: age slot i_idx
    assign missed_inc = (r_missed[i_idx] == MISSED_SAT) ? r_missed[i_idx]
                                                        : r_missed[i_idx] + 1'b1;
    assign kill = (missed_inc > {1'b0, r_ftd});

    // last pipe stage: squared distance and compare
    assign d2 = {2'b00, r_s3_sqx[SQ_MAG_W-1:0]} + {2'b00, r_s3_sqy[SQ_MAG_W-1:0]}
              + {2'b00, r_s3_sqz[SQ_MAG_W-1:0]};
    assign elig     = r_valid[r_s3_idx] && !r_found[r_s3_idx];
    assign upd_best = r_s3_vld && elig && (d2 < D2_W'(r_lim2))
                      && (!r_have_best || (d2 < r_best_d));
    assign upd_free = r_s3_vld && !r_valid[r_s3_idx] && !r_have_free;

    assign det_commit = i_ctl.commit && (r_cmd == CMD_DETECT);
    assign wr_idx     = r_have_best ? r_best_idx : r_free_idx;
    assign mem_we     = det_commit && (r_have_best || r_have_free);
    assign id_we      = det_commit && !r_have_best && r_have_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_found     <= '0;
            for (int k = 0; k < MAX_TRACKS; k++) begin
                r_missed[k] <= '0;
            end
            r_live      <= '0;
            r_removed   <= '0;
            r_next_id   <= '0;
            r_have_best <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_removed   <= '0;
                r_have_best <= 1'b0;
                r_have_free <= 1'b0;
            end
            if (i_ctl.frame_step && r_valid[i_idx]) begin
                r_found[i_idx] <= 1'b0;
                if (kill) begin
                    r_valid[i_idx]  <= 1'b0;
                    r_missed[i_idx] <= '0;
                    r_removed       <= r_removed + 1'b1;
                    r_live          <= r_live - 1'b1;
                end else begin
                    r_missed[i_idx] <= missed_inc;
                end
            end
            if (upd_best) begin
                r_have_best <= 1'b1;
                r_best_idx  <= r_s3_idx;
                r_best_d    <= d2;
                r_best_id   <= r_s3_id;
            end
            if (upd_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_s3_idx;
            end
            if (det_commit) begin
                if (r_have_best) begin
                    r_found[r_best_idx]  <= 1'b1;
                    r_missed[r_best_idx] <= '0;
                end else if (r_have_free) begin
                    r_valid[r_free_idx]  <= 1'b1;
                    r_found[r_free_idx]  <= 1'b0;
                    r_missed[r_free_idx] <= '0;
                    r_next_id            <= r_next_id + 1'b1;
                    r_live               <= r_live + 1'b1;
                end
            end
        end
    end

    // position and ID store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_pos[wr_idx] <= {r_px, r_py, r_pz};
        end
        if (id_we) begin
            mem_id[wr_idx] <= r_next_id;
        end
        r_rd_pos <= mem_pos[i_idx];
        r_rd_id  <= mem_id[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_s2_idx <= r_s1_idx;
        r_s2_id  <= r_rd_id;
        r_s2_dx  <= {r_rd_pos[3*POS_W-1], r_rd_pos[3*POS_W-1:2*POS_W]}
                  - {r_px[POS_W-1], r_px};
        r_s2_dy  <= {r_rd_pos[2*POS_W-1], r_rd_pos[2*POS_W-1:POS_W]}
                  - {r_py[POS_W-1], r_py};
        r_s2_dz  <= {r_rd_pos[POS_W-1], r_rd_pos[POS_W-1:0]}
                  - {r_pz[POS_W-1], r_pz};
        r_s3_idx <= r_s2_idx;
        r_s3_id  <= r_s2_id;
        r_s3_sqx <= r_s2_dx * r_s2_dx;
        r_s3_sqy <= r_s2_dy * r_s2_dy;
        r_s3_sqz <= r_s2_dz * r_s2_dz;
    end

    always_comb begin
        n_res = '0;
        if (r_cmd == CMD_FRAME) begin
            n_res.live_count    = COUNT_W'(r_live);
            n_res.removed_count = COUNT_W'(r_removed);
        end else if (r_have_best) begin
            n_res.track_id   = r_best_id;
            n_res.slot       = SLOT_W'(r_best_idx);
            n_res.live_count = COUNT_W'(r_live);
        end else if (r_have_free) begin
            n_res.track_id   = r_next_id;
            n_res.slot       = SLOT_W'(r_free_idx);
            n_res.is_new     = 1'b1;
            n_res.live_count = COUNT_W'(r_live + 1'b1);
        end else begin
            n_res.dropped    = 1'b1;
            n_res.live_count = COUNT_W'(r_live);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_res <= n_res;
        end
    end

    assign o_stat.pipe_busy = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_res            = r_res;

endmodule

`default_nettype wire

// File: rtl/core/nearest_track_associator_unit.sv
// Channel   Signals                                  Transfer
// input     i_start, o_busy, i_in (t_in)             i_start high while o_busy low
// result    o_res_valid, o_res (t_out)               one cycle per strobe, no stall
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,   valid and ready high
//           i_cfg_data
//
// A frame start ages one slot per cycle between accept and result strobe. A detection
// sends one slot per cycle into the four-stage distance pipe (store read, difference,
// square, sum and compare), waits for the pipe to drain, then the commit state updates
// the table. o_busy drops in the cycle the result is strobed, so the next beat may be
// accepted then. Synchronous active-low reset empties the table and restores both
// registers; the result side cannot stall.
`default_nettype none

module nearest_track_associator_unit import nta_pkg::*; #(
    parameter int MAX_TRACKS = NTA_MAX_TRACKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_in               i_in,
    output logic                   o_res_valid,
    output t_out                   o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_reg_idx          i_cfg_index,
    input  wire logic [DIST_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    t_dp_ctl          ctl;
    t_dp_stat         stat;
    logic [IDX_W-1:0] idx;

    assign o_cfg_ready = 1'b1;

    nta_ctrl #(
        .MAX_TRACKS (MAX_TRACKS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_in.cmd),
        .i_stat      (stat),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid),
        .o_ctl       (ctl),
        .o_idx       (idx)
    );

    nta_dp #(
        .MAX_TRACKS (MAX_TRACKS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_idx       (idx),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_res       (o_res)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_new_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.is_new && o_res.dropped))
        else $error("result both new and dropped");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.dropped) |-> (o_res.live_count == COUNT_W'(MAX_TRACKS)))
        else $error("detection dropped with free slots");

endmodule

`default_nettype wire
